// ===== hdl/icrt_pkg.sv =====
// shared types, constants and functions for the radix text converter
`timescale 1ns / 1ps

package icrt_pkg;

  localparam int unsigned MAX_RADIX    = 16;
  localparam int unsigned BUFFER_DEPTH = 32;

  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_PLUS  = 7'h2b;
  localparam logic [7:0] CHAR_LOW   = 8'h20;
  localparam logic [7:0] CHAR_HIGH  = 8'h7e;

  localparam logic [1:0] REG_RADIX      = 2'd0;
  localparam logic [1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [1:0] REG_CHARS_HIGH = 2'd2;

  localparam logic [4:0]  RADIX_RESET      = 5'd10;
  localparam logic [63:0] CHARS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [63:0] CHARS_HIGH_RESET = 64'h6665646362613938;

  typedef struct packed {
    logic [4:0]   radix;
    logic [127:0] chars;
  } cfg_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } job_t;

  // full byte of the character for one digit
  function automatic logic [7:0] char_byte(input cfg_t cfg, input logic [3:0] d);
    char_byte = cfg.chars[{d, 3'b000} +: 8];
  endfunction

  function automatic logic alphabet_ok(input cfg_t cfg);
    logic       ok;
    logic [7:0] c;
    ok = (cfg.radix >= 5'd2) && (cfg.radix <= 5'(MAX_RADIX));
    for (int i = 0; i < 16; i++) begin
      c = char_byte(cfg, 4'(i));
      if (5'(i) < cfg.radix) begin
        if (c < CHAR_LOW || c > CHAR_HIGH) ok = 1'b0;
        if (c == {1'b0, CHAR_PLUS} || c == {1'b0, CHAR_MINUS}) ok = 1'b0;
        for (int j = 0; j < i; j++) begin
          if (char_byte(cfg, 4'(j)) == c) ok = 1'b0;
        end
      end
    end
    alphabet_ok = ok;
  endfunction

  // floor(2^32 / d), the estimate is at most one below the true quotient
  function automatic logic [31:0] recip(input logic [4:0] d);
    unique case (d)
      5'd2:    recip = 32'd2147483648;
      5'd3:    recip = 32'd1431655765;
      5'd4:    recip = 32'd1073741824;
      5'd5:    recip = 32'd858993459;
      5'd6:    recip = 32'd715827882;
      5'd7:    recip = 32'd613566756;
      5'd8:    recip = 32'd536870912;
      5'd9:    recip = 32'd477218588;
      5'd10:   recip = 32'd429496729;
      5'd11:   recip = 32'd390451572;
      5'd12:   recip = 32'd357913941;
      5'd13:   recip = 32'd330382099;
      5'd14:   recip = 32'd306783378;
      5'd15:   recip = 32'd286331153;
      5'd16:   recip = 32'd268435456;
      default: recip = 32'd0;
    endcase
  endfunction

endpackage

// ===== hdl/icrt_front.sv =====
// input stage: holds one number, checks the alphabet, hands jobs to the queue or drops them on a bad alphabet
`timescale 1ns / 1ps

module icrt_front (
  input  logic           clk,
  input  logic           rst,
  input  icrt_pkg::cfg_t cfg,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [31:0]    s_tdata,
  input  logic           q_full,
  output logic           push,
  output icrt_pkg::job_t push_job
);
  import icrt_pkg::*;

  logic        hold_valid;
  logic [31:0] hold_num;
  logic        ok;
  logic        consume;
  logic        accept;

  assign ok       = alphabet_ok(cfg);
  assign consume  = hold_valid && (!ok || !q_full);
  assign push     = hold_valid && ok && !q_full;
  assign s_tready = !hold_valid || consume;
  assign accept   = s_tvalid && s_tready;

  assign push_job.neg = hold_num[31];
  assign push_job.mag = hold_num[31] ? (32'd0 - hold_num) : hold_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (consume) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_num <= s_tdata;
    end
  end

endmodule

// ===== hdl/icrt_queue.sv =====
// two-entry job queue between the front and back parts
`timescale 1ns / 1ps

module icrt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  icrt_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output icrt_pkg::job_t pop_job
);
  import icrt_pkg::*;

  job_t       ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_job   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== hdl/icrt_back.sv =====
// digit engine: reciprocal division per digit, then a minus sign if negative and characters out most significant first
`timescale 1ns / 1ps

module icrt_back (
  input  logic           clk,
  input  logic           rst,
  input  icrt_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  icrt_pkg::job_t q_job,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast
);
  import icrt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SGN  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_CH   = 3'd5;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic        neg;
  logic [31:0] magnitude;
  logic [63:0] prod;
  logic [5:0]  digit_count;

  logic [3:0]  digit_buffer [BUFFER_DEPTH];
  logic        wr_en;
  logic [4:0]  wr_addr;
  logic [3:0]  wr_digit;
  logic        rd_en;
  logic [3:0]  rd_data;
  logic [7:0]  rd_char;

  logic [31:0] q0;
  logic [31:0] qd;
  logic [31:0] r0;
  logic        corr;
  logic [31:0] quot;
  logic [3:0]  rem;

  logic        out_valid;
  logic [6:0]  out_char;
  logic        out_last;
  logic        out_free;

  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_char};
  assign m_tlast  = out_last;

  assign pop = (state == ST_IDLE) && q_valid;

  assign rd_char = char_byte(cfg, rd_data);

  // estimate from the reciprocal, then one correction step
  assign q0   = prod[63:32];
  assign qd   = q0 * {27'd0, cfg.radix};
  assign r0   = magnitude - qd;
  assign corr = (r0 >= {27'd0, cfg.radix});
  assign quot = corr ? (q0 + 32'd1) : q0;
  assign rem  = corr ? 4'(r0 - {27'd0, cfg.radix}) : r0[3:0];

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = digit_count[4:0];
    wr_digit = rem;
    rd_en    = (state == ST_RD);
    if (pop && q_job.mag == 32'd0) begin
      wr_en    = 1'b1;
      wr_addr  = 5'd0;
      wr_digit = 4'd0;
    end else if (state == ST_DIV) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_job.mag == 32'd0) begin
            state_next = q_job.neg ? ST_SGN : ST_RD;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: begin
        if (quot == 32'd0) begin
          state_next = neg ? ST_SGN : ST_RD;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_SGN: if (out_free) state_next = ST_RD;
      ST_RD:  state_next = ST_CH;
      ST_CH: begin
        if (out_free) begin
          state_next = (digit_count == 6'd1) ? ST_IDLE : ST_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      neg         <= 1'b0;
      magnitude   <= 32'd0;
      digit_count <= 6'd0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        neg         <= q_job.neg;
        magnitude   <= q_job.mag;
        digit_count <= (q_job.mag == 32'd0) ? 6'd1 : 6'd0;
      end else if (state == ST_DIV) begin
        magnitude   <= quot;
        digit_count <= digit_count + 6'd1;
      end else if (state == ST_CH && out_free) begin
        digit_count <= digit_count - 6'd1;
      end
      if ((state == ST_SGN || state == ST_CH) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= 64'(magnitude) * 64'(recip(cfg.radix));
    end
    if (state == ST_SGN && out_free) begin
      out_char <= CHAR_MINUS;
      out_last <= 1'b0;
    end else if (state == ST_CH && out_free) begin
      out_char <= rd_char[6:0];
      out_last <= (digit_count == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_buffer[wr_addr] <= wr_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= digit_buffer[5'(digit_count - 6'd1)];
    end
  end

endmodule

// ===== hdl/integer_to_custom_radix_text_core.sv =====
// with no stalls, each word goes through the front hold register and the queue, then the back
// part runs a multiply step and a division step per digit, none for zero, then a sign step
// if negative, then a read step and a character step for each digit
// the back part pops a new number only from its idle state, once the previous one is done;
// the front and a two-entry queue accept and check the next words meanwhile
// reset is synchronous: control and queue clear, config returns to radix 10 and "0123456789abcdef"
`timescale 1ns / 1ps

module integer_to_custom_radix_text_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // number
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // character, zero pad bit
  output logic        m_tlast
);
  import icrt_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic q_valid;
  job_t q_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix <= RADIX_RESET;
      cfg.chars <= {CHARS_HIGH_RESET, CHARS_LOW_RESET};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:      cfg.radix <= cfg_data[4:0];
        REG_CHARS_LOW:  cfg.chars[63:0] <= cfg_data;
        REG_CHARS_HIGH: cfg.chars[127:64] <= cfg_data;
        default: ;
      endcase
    end
  end

  icrt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  icrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_job   (q_job)
  );

  icrt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== hdl/icrt_checker.sv =====
// port-level checks for the radix text converter, bound to the top level
`timescale 1ns / 1ps

module icrt_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_printable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata >= 8'h20 && m_tdata <= 8'h7e)
    else $error("non-printable character");

  // the sign is never the whole text
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata == 8'h2d |-> !m_tlast)
    else $error("minus sign marked last");

endmodule

bind integer_to_custom_radix_text_core icrt_checker u_icrt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
